FILE: rtl/wft_pkg.sv
// Package for the wrench frame transform: request and response payload
// structs, register index codes and fixed-point constants.
// Has no dependencies; imported by wrench_frame_transform.
package wft_pkg;

   localparam int DATA_W  = 32;
   localparam int CSR_IDX_W = 3;
   localparam int STAGES  = 6;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_QUAT_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUAT_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUAT_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUAT_W   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Z = 3'd6;

   // unity in Q1.30, at the width of the matrix entry arithmetic
   localparam logic signed [37:0] ONE_Q30 = 38'sd1073741824;
   localparam logic signed [31:0] QUAT_W_RESET = 32'sd1073741824;

   typedef struct packed {
      logic signed [DATA_W-1:0] force_in_x;
      logic signed [DATA_W-1:0] force_in_y;
      logic signed [DATA_W-1:0] force_in_z;
      logic signed [DATA_W-1:0] torque_in_x;
      logic signed [DATA_W-1:0] torque_in_y;
      logic signed [DATA_W-1:0] torque_in_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] force_out_x;
      logic signed [DATA_W-1:0] force_out_y;
      logic signed [DATA_W-1:0] force_out_z;
      logic signed [DATA_W-1:0] torque_out_x;
      logic signed [DATA_W-1:0] torque_out_y;
      logic signed [DATA_W-1:0] torque_out_z;
   } rsp_payload_type;

endpackage

FILE: rtl/wrench_frame_transform.sv
// A request accepted into stage 0 moves through stages 1 to 5 and then shows on rsp_valid.
// Throughput: one request per cycle while rsp_stall is low; six register stages, each
// holding one multiply bank or one wide add and saturate; all may hold a request at once.
// Each stage advances whenever the stage after it is empty or advancing, so bubbles close.
// Reset (synchronous, active high) empties all stages and loads the identity rotation
// with zero lever arm; no clearing pass, the block accepts requests the cycle after.
// Depends on wft_pkg.
module wrench_frame_transform (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  wft_pkg::req_payload_type req_payload,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output wft_pkg::rsp_payload_type rsp_payload,
   // register write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [wft_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wft_pkg::DATA_W-1:0]    csr_data
);
   import wft_pkg::*;

   // floor(a*b / 2^30) of two Q1.30 quaternion components
   function automatic logic signed [33:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return 34'(p >>> 30);
   endfunction

   // clamp a matrix entry to [-1, 1] in Q1.30
   function automatic logic signed [31:0] clamp_q30(input logic signed [37:0] a);
      logic signed [31:0] r;
      if (a > ONE_Q30) begin
         r = 32'(ONE_Q30);
      end else if (a < -ONE_Q30) begin
         r = 32'(-ONE_Q30);
      end else begin
         r = a[31:0];
      end
      return r;
   endfunction

   // saturate to the 32 bit signed range
   function automatic logic signed [31:0] sat32(input logic signed [65:0] a);
      logic signed [31:0] r;
      if (a[65:31] != {35{a[65]}}) begin
         r = a[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = a[31:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers: always ready; writes to unknown indexes drop
   // ---------------------------------------------------------------------
   logic signed [31:0] quat_ff   [4];
   logic signed [31:0] quat_in   [4];
   logic signed [31:0] offset_ff [3];
   logic signed [31:0] offset_in [3];

   assign csr_ready = 1'b1;

   always_comb begin
      quat_in   = quat_ff;
      offset_in = offset_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_QUAT_X:   quat_in[0]   = csr_data;
            CSR_QUAT_Y:   quat_in[1]   = csr_data;
            CSR_QUAT_Z:   quat_in[2]   = csr_data;
            CSR_QUAT_W:   quat_in[3]   = csr_data;
            CSR_OFFSET_X: offset_in[0] = csr_data;
            CSR_OFFSET_Y: offset_in[1] = csr_data;
            CSR_OFFSET_Z: offset_in[2] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff[0]   <= '0;
         quat_ff[1]   <= '0;
         quat_ff[2]   <= '0;
         quat_ff[3]   <= QUAT_W_RESET;
         offset_ff[0] <= '0;
         offset_ff[1] <= '0;
         offset_ff[2] <= '0;
      end else begin
         quat_ff   <= quat_in;
         offset_ff <= offset_in;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control: a valid bit per stage, advance when the next stage
   // is empty or itself advancing
   // ---------------------------------------------------------------------
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] stage_en;

   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in = valid_ff;
      if (stage_en[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (stage_en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = valid_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 0: capture the sample, form the nine products of the quaternion read here.
   // Config is held stable by the user while requests are in flight, not by the block.
   // ---------------------------------------------------------------------
   logic signed [31:0] f0_ff [3], f0_in [3];
   logic signed [31:0] t0_ff [3], t0_in [3];
   logic signed [33:0] p_xx_ff, p_yy_ff, p_zz_ff, p_xy_ff, p_xz_ff;
   logic signed [33:0] p_yz_ff, p_xw_ff, p_yw_ff, p_zw_ff;
   logic signed [33:0] p_xx_in, p_yy_in, p_zz_in, p_xy_in, p_xz_in;
   logic signed [33:0] p_yz_in, p_xw_in, p_yw_in, p_zw_in;

   always_comb begin
      f0_in[0] = req_payload.force_in_x;
      f0_in[1] = req_payload.force_in_y;
      f0_in[2] = req_payload.force_in_z;
      t0_in[0] = req_payload.torque_in_x;
      t0_in[1] = req_payload.torque_in_y;
      t0_in[2] = req_payload.torque_in_z;
      p_xx_in  = qmul(quat_ff[0], quat_ff[0]);
      p_yy_in  = qmul(quat_ff[1], quat_ff[1]);
      p_zz_in  = qmul(quat_ff[2], quat_ff[2]);
      p_xy_in  = qmul(quat_ff[0], quat_ff[1]);
      p_xz_in  = qmul(quat_ff[0], quat_ff[2]);
      p_yz_in  = qmul(quat_ff[1], quat_ff[2]);
      p_xw_in  = qmul(quat_ff[0], quat_ff[3]);
      p_yw_in  = qmul(quat_ff[1], quat_ff[3]);
      p_zw_in  = qmul(quat_ff[2], quat_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         f0_ff   <= f0_in;
         t0_ff   <= t0_in;
         p_xx_ff <= p_xx_in;
         p_yy_ff <= p_yy_in;
         p_zz_ff <= p_zz_in;
         p_xy_ff <= p_xy_in;
         p_xz_ff <= p_xz_in;
         p_yz_ff <= p_yz_in;
         p_xw_ff <= p_xw_in;
         p_yw_ff <= p_yw_in;
         p_zw_ff <= p_zw_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: rotation matrix entries, clamped to [-1, 1]
   // ---------------------------------------------------------------------
   logic signed [31:0] f1_ff [3];
   logic signed [31:0] t1_ff [3];
   logic signed [31:0] m_ff [3][3];
   logic signed [31:0] m_in [3][3];

   always_comb begin
      m_in[0][0] = clamp_q30(ONE_Q30 - ((38'(p_yy_ff) + 38'(p_zz_ff)) <<< 1));
      m_in[0][1] = clamp_q30((38'(p_xy_ff) - 38'(p_zw_ff)) <<< 1);
      m_in[0][2] = clamp_q30((38'(p_xz_ff) + 38'(p_yw_ff)) <<< 1);
      m_in[1][0] = clamp_q30((38'(p_xy_ff) + 38'(p_zw_ff)) <<< 1);
      m_in[1][1] = clamp_q30(ONE_Q30 - ((38'(p_xx_ff) + 38'(p_zz_ff)) <<< 1));
      m_in[1][2] = clamp_q30((38'(p_yz_ff) - 38'(p_xw_ff)) <<< 1);
      m_in[2][0] = clamp_q30((38'(p_xz_ff) - 38'(p_yw_ff)) <<< 1);
      m_in[2][1] = clamp_q30((38'(p_yz_ff) + 38'(p_xw_ff)) <<< 1);
      m_in[2][2] = clamp_q30(ONE_Q30 - ((38'(p_xx_ff) + 38'(p_yy_ff)) <<< 1));
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         f1_ff <= f0_ff;
         t1_ff <= t0_ff;
         m_ff  <= m_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: matrix by force and by torque, eighteen products
   // ---------------------------------------------------------------------
   logic signed [63:0] pf_ff [3][3], pf_in [3][3];
   logic signed [63:0] pt_ff [3][3], pt_in [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pf_in[i][j] = 64'(m_ff[i][j]) * 64'(f1_ff[j]);
            pt_in[i][j] = 64'(m_ff[i][j]) * 64'(t1_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         pf_ff <= pf_in;
         pt_ff <= pt_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: row sums, back to Q15.16; saturate the force only
   // ---------------------------------------------------------------------
   logic signed [31:0] fr3_ff [3], fr3_in [3];
   logic signed [35:0] tr3_ff [3], tr3_in [3];

   always_comb begin
      logic signed [65:0] acc_f;
      logic signed [65:0] acc_t;
      for (int i = 0; i < 3; i++) begin
         acc_f = (66'(pf_ff[i][0]) + 66'(pf_ff[i][1]) + 66'(pf_ff[i][2])) >>> 30;
         acc_t = (66'(pt_ff[i][0]) + 66'(pt_ff[i][1]) + 66'(pt_ff[i][2])) >>> 30;
         fr3_in[i] = sat32(acc_f);
         tr3_in[i] = acc_t[35:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         fr3_ff <= fr3_in;
         tr3_ff <= tr3_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: lever arm crossed with the rotated force
   // ---------------------------------------------------------------------
   logic signed [31:0] fr4_ff [3];
   logic signed [35:0] tr4_ff [3];
   logic signed [63:0] cpa_ff [3], cpa_in [3];
   logic signed [63:0] cpb_ff [3], cpb_in [3];

   always_comb begin
      cpa_in[0] = 64'(offset_ff[1]) * 64'(fr3_ff[2]);
      cpb_in[0] = 64'(offset_ff[2]) * 64'(fr3_ff[1]);
      cpa_in[1] = 64'(offset_ff[2]) * 64'(fr3_ff[0]);
      cpb_in[1] = 64'(offset_ff[0]) * 64'(fr3_ff[2]);
      cpa_in[2] = 64'(offset_ff[0]) * 64'(fr3_ff[1]);
      cpb_in[2] = 64'(offset_ff[1]) * 64'(fr3_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         fr4_ff <= fr3_ff;
         tr4_ff <= tr3_ff;
         cpa_ff <= cpa_in;
         cpb_ff <= cpb_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: output register; add the cross term and saturate the torque
   // ---------------------------------------------------------------------
   rsp_payload_type rsp_ff, rsp_in;
   logic signed [31:0] tq_out [3];

   always_comb begin
      logic signed [65:0] cross_term;
      for (int i = 0; i < 3; i++) begin
         cross_term = (66'(cpa_ff[i]) - 66'(cpb_ff[i])) >>> 16;
         tq_out[i]  = sat32(cross_term + 66'(tr4_ff[i]));
      end
      rsp_in.force_out_x  = fr4_ff[0];
      rsp_in.force_out_y  = fr4_ff[1];
      rsp_in.force_out_z  = fr4_ff[2];
      rsp_in.torque_out_x = tq_out[0];
      rsp_in.torque_out_y = tq_out[1];
      rsp_in.torque_out_z = tq_out[2];
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // a draining output frees the whole chain back to the request side
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |-> !req_stall)
      else $error("request stalled while the output drains");

   // an accepted request lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted request lost at the first stage");

   // an empty first stage never stalls the request side
   assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0] |-> !req_stall)
      else $error("request stalled with an empty first stage");

   // clamped matrix entries [0][0] and [1][2] stay within unity
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> (m_ff[0][0] <= 32'sd1073741824 && m_ff[0][0] >= -32'sd1073741824
                       && m_ff[1][2] <= 32'sd1073741824 && m_ff[1][2] >= -32'sd1073741824))
      else $error("matrix entry outside unity");
`endif

endmodule

FILE: bench/wrench_frame_transform_tb.sv
// Self-checking bench for wrench_frame_transform: a directed table, then random frames and
// samples; responses checked field by field against typed results or a bit-exact predictor.
// Depends on wft_pkg (payload structs, register indexes) and the wrench_frame_transform RTL.
module wrench_frame_transform_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wft_pkg::*;

   // pipeline depth quoted at the head of the block, used for drain and config pauses
   localparam int PIPE_DEPTH     = 6;
   localparam int SQUEEZE_CYCLES = 60;
   localparam int WATCHDOG_LIMIT = 2000;

   // index past the last register: writes to it must be dropped by the block
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   localparam logic [31:0] LIM_MAX    = 32'h7fff_ffff;
   localparam logic [31:0] LIM_MIN    = 32'h8000_0000;
   localparam logic [31:0] Q30_POS    = 32'h4000_0000;
   localparam logic [31:0] Q30_NEG    = 32'hc000_0000;
   localparam logic [31:0] HALF_SQRT2 = 32'h2d41_3ccd;   // cos(45 deg) in Q1.30
   localparam logic [31:0] ONE_Q16    = 32'h0001_0000;

   localparam longint ONE_Q30_L = 64'sd1073741824;

   typedef logic signed [95:0] wide_type;
   localparam wide_type WIDE_MAX = 96'sh7fff_ffff;
   localparam wide_type WIDE_MIN = -96'sh8000_0000;

   typedef enum {FRAME_UNIT_NEAR, FRAME_UNIT_FAR, FRAME_LOOSE, FRAME_EXTREME} frame_kind_type;

   // one line of the directed table: either a register write or a request
   typedef struct {
      bit                    is_write;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [31:0]           reg_data;
      req_payload_type       sample;
      bit                    typed;
      rsp_payload_type       typed_result;
   } bench_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [DATA_W-1:0]     csr_data = '0;

   // travels alongside the request so the monitor knows whether a typed result applies
   bit                    req_typed = 1'b0;
   rsp_payload_type       req_typed_result = '0;

   bench_row_type         stim_rows [$];
   rsp_payload_type       pending_wrenches [$];
   logic signed [31:0]    cfg_shadow [7];
   int                    mismatches = 0;
   int                    quiet_cycles = 0;
   bit                    idle_on = 1'b1;
   int                    squeeze_req = 0;
   int                    squeeze_seen = 0;
   int                    hold_left = 0;

   string field_names [6] = '{"force_out_x", "force_out_y", "force_out_z",
                              "torque_out_x", "torque_out_y", "torque_out_z"};

   wrench_frame_transform u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   function automatic logic signed [31:0] clamp32(input wide_type v);
      if (v > WIDE_MAX) return 32'sh7fff_ffff;
      if (v < WIDE_MIN) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // Build the rotation matrix from the held quaternion, rotate force and torque, then add
   // the lever arm crossed with the rotated (already saturated) force.  Every right shift is
   // arithmetic, so truncation goes towards minus infinity throughout.
   function automatic rsp_payload_type transform_wrench(input req_payload_type s);
      longint qx, qy, qz, qw;
      longint xx, yy, zz, xy, xz, yz, xw, yw, zw;
      longint rot [3][3];
      wide_type arm [3], fv [3], tv [3], fr [3], tr [3];
      wide_type acc;
      logic signed [31:0] f_out [3], t_out [3];
      qx = cfg_shadow[CSR_QUAT_X];
      qy = cfg_shadow[CSR_QUAT_Y];
      qz = cfg_shadow[CSR_QUAT_Z];
      qw = cfg_shadow[CSR_QUAT_W];
      xx = (qx * qx) >>> 30;  yy = (qy * qy) >>> 30;  zz = (qz * qz) >>> 30;
      xy = (qx * qy) >>> 30;  xz = (qx * qz) >>> 30;  yz = (qy * qz) >>> 30;
      xw = (qx * qw) >>> 30;  yw = (qy * qw) >>> 30;  zw = (qz * qw) >>> 30;
      rot[0][0] = ONE_Q30_L - 2 * (yy + zz);
      rot[0][1] = 2 * (xy - zw);
      rot[0][2] = 2 * (xz + yw);
      rot[1][0] = 2 * (xy + zw);
      rot[1][1] = ONE_Q30_L - 2 * (xx + zz);
      rot[1][2] = 2 * (yz - xw);
      rot[2][0] = 2 * (xz - yw);
      rot[2][1] = 2 * (yz + xw);
      rot[2][2] = ONE_Q30_L - 2 * (xx + yy);
      // a quaternion off unit length is not normalised; the entry clamp bounds it instead
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            if (rot[i][j] > ONE_Q30_L) rot[i][j] = ONE_Q30_L;
            else if (rot[i][j] < -ONE_Q30_L) rot[i][j] = -ONE_Q30_L;
         end
      arm[0] = cfg_shadow[CSR_OFFSET_X];
      arm[1] = cfg_shadow[CSR_OFFSET_Y];
      arm[2] = cfg_shadow[CSR_OFFSET_Z];
      fv[0] = s.force_in_x;   fv[1] = s.force_in_y;   fv[2] = s.force_in_z;
      tv[0] = s.torque_in_x;  tv[1] = s.torque_in_y;  tv[2] = s.torque_in_z;
      for (int i = 0; i < 3; i++) begin
         acc      = rot[i][0] * fv[0] + rot[i][1] * fv[1] + rot[i][2] * fv[2];
         f_out[i] = clamp32(acc >>> 30);
         fr[i]    = f_out[i];
         acc      = rot[i][0] * tv[0] + rot[i][1] * tv[1] + rot[i][2] * tv[2];
         tr[i]    = acc >>> 30;
      end
      // rotated torque stays unsaturated until the lever arm term is in
      tr[0] = tr[0] + ((arm[1] * fr[2] - arm[2] * fr[1]) >>> 16);
      tr[1] = tr[1] + ((arm[2] * fr[0] - arm[0] * fr[2]) >>> 16);
      tr[2] = tr[2] + ((arm[0] * fr[1] - arm[1] * fr[0]) >>> 16);
      for (int i = 0; i < 3; i++)
         t_out[i] = clamp32(tr[i]);
      return {f_out[0], f_out[1], f_out[2], t_out[0], t_out[1], t_out[2]};
   endfunction

   function automatic void compare_wrench(input rsp_payload_type want, input rsp_payload_type got);
      logic [191:0] w, g;
      w = want;
      g = got;
      for (int k = 0; k < 6; k++)
         if (w[191-32*k -: 32] !== g[191-32*k -: 32]) begin
            $display("%0t: %s expected %0d (0x%08h) actual %0d (0x%08h)", $time,
                     field_names[k], $signed(w[191-32*k -: 32]), w[191-32*k -: 32],
                     $signed(g[191-32*k -: 32]), g[191-32*k -: 32]);
            mismatches++;
         end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Monitor: track register writes, check responses, then log the request accepted at this
   // edge.  All three live in one process so their order within a step is fixed.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         cfg_shadow[CSR_QUAT_X]   = '0;
         cfg_shadow[CSR_QUAT_Y]   = '0;
         cfg_shadow[CSR_QUAT_Z]   = '0;
         cfg_shadow[CSR_QUAT_W]   = Q30_POS;
         cfg_shadow[CSR_OFFSET_X] = '0;
         cfg_shadow[CSR_OFFSET_Y] = '0;
         cfg_shadow[CSR_OFFSET_Z] = '0;
         pending_wrenches.delete();
      end else begin
         // drop writes past the last register, as the block must
         if (csr_valid && csr_ready && csr_index <= CSR_OFFSET_Z)
            cfg_shadow[csr_index] = csr_data;
         if (rsp_valid && !rsp_stall) begin
            if (pending_wrenches.size() == 0) begin
               $display("%0t: response with nothing expected, expected none actual 0x%048h",
                        $time, rsp_payload);
               mismatches++;
            end else begin
               compare_wrench(pending_wrenches.pop_front(), rsp_payload);
            end
         end
         if (req_valid && !req_stall)
            pending_wrenches.push_back(req_typed ? req_typed_result
                                                 : transform_wrench(req_payload));
      end
   end

   // ---------------------------------------------------------------------------------------
   // Receiver: stall bursts of random length, plus a long hold-off on request from the
   // sender so the pipeline fills and pushes back on the request side.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         hold_left    <= 0;
         squeeze_seen <= 0;
      end else if (squeeze_seen != squeeze_req) begin
         squeeze_seen <= squeeze_req;
         hold_left    <= SQUEEZE_CYCLES;
         rsp_stall    <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         hold_left <= $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: give up when no handshake of any kind has happened for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------

   function automatic logic [191:0] mk_six(input logic [31:0] a, b, c, d, e, f);
      return {a, b, c, d, e, f};
   endfunction

   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      bench_row_type row;
      row          = '{default: '0};
      row.is_write  = 1'b1;
      row.reg_index = idx;
      row.reg_data  = val;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_sample(input req_payload_type s, input bit typed,
                                      input rsp_payload_type r);
      bench_row_type row;
      row              = '{default: '0};
      row.sample       = s;
      row.typed        = typed;
      row.typed_result = r;
      stim_rows.push_back(row);
   endfunction

   // moderate values keep the forces clear of saturation; the rest are random or corners
   function automatic logic [31:0] pick_component(input int kind);
      logic [31:0] corner [5];
      corner = '{LIM_MAX, LIM_MIN, 32'h0, 32'hffff_ffff, 32'h1};
      if (kind < 60) return 32'(int'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000);
      if (kind < 85) return $urandom;
      return corner[$urandom_range(0, 4)];
   endfunction

   function automatic req_payload_type random_sample();
      int kind;
      kind = $urandom_range(0, 99);
      return mk_six(pick_component(kind), pick_component(kind), pick_component(kind),
                    pick_component(kind), pick_component(kind), pick_component(kind));
   endfunction

   // Offer one request and hold it until accepted.  A random gap may come first.
   task automatic send_sample(input req_payload_type s, input bit typed,
                              input rsp_payload_type r);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_payload      <= s;
      req_typed        <= typed;
      req_typed_result <= r;
      do @(posedge clock); while (req_stall);
   endtask

   // Registers change only with the pipeline empty: drain, let the latency pass, then write.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_wrenches.size() != 0);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_frame(input frame_kind_type kind);
      real         c [4];
      real         norm;
      logic [31:0] quat [4];
      logic [31:0] arm [3];
      logic [31:0] q_corner [3];
      logic [31:0] a_corner [3];
      q_corner = '{Q30_NEG, 32'h0, Q30_POS};
      a_corner = '{LIM_MIN, 32'h0, LIM_MAX};
      for (int k = 0; k < 4; k++)
         c[k] = (real'(int'($urandom_range(0, 2000))) - 1000.0) / 1000.0;
      norm = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
      if (norm < 0.05) begin
         c[0] = 0.0; c[1] = 0.0; c[2] = 0.0; c[3] = 1.0;
         norm = 1.0;
      end
      for (int k = 0; k < 4; k++) begin
         case (kind)
            FRAME_LOOSE:   quat[k] = 32'(longint'($urandom_range(0, 32'h8000_0000))
                                         - ONE_Q30_L);
            FRAME_EXTREME: quat[k] = q_corner[$urandom_range(0, 2)];
            default:       quat[k] = $rtoi(c[k] / norm * 1073741824.0);
         endcase
      end
      for (int k = 0; k < 3; k++) begin
         case (kind)
            FRAME_UNIT_FAR: arm[k] = $urandom;
            FRAME_EXTREME:  arm[k] = a_corner[$urandom_range(0, 2)];
            default:        arm[k] = 32'(int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000);
         endcase
      end
      write_register(CSR_QUAT_X, quat[0]);
      write_register(CSR_QUAT_Y, quat[1]);
      write_register(CSR_QUAT_Z, quat[2]);
      write_register(CSR_QUAT_W, quat[3]);
      write_register(CSR_OFFSET_X, arm[0]);
      write_register(CSR_OFFSET_Y, arm[1]);
      write_register(CSR_OFFSET_Z, arm[2]);
   endtask

   // A phase: one frame, then a run of random requests.  Optionally the receiver is asked
   // to hold off for a long stretch early in the phase while requests keep coming.
   task automatic run_phase(input frame_kind_type kind, input bit with_idle, input int count,
                            input bit squeeze);
      idle_on = with_idle;
      set_frame(kind);
      for (int n = 0; n < count; n++) begin
         if (squeeze && n == 30)
            squeeze_req <= squeeze_req + 1;
         send_sample(random_sample(), 1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      // After reset the frame is the identity with no lever arm, so each response must
      // echo its request exactly; those rows carry the result typed in.
      add_sample(mk_six('0, '0, '0, '0, '0, '0), 1'b1, mk_six('0, '0, '0, '0, '0, '0));
      add_sample(mk_six(LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX), 1'b1,
                 mk_six(LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX));
      add_sample(mk_six(LIM_MIN, LIM_MIN, LIM_MIN, LIM_MIN, LIM_MIN, LIM_MIN), 1'b1,
                 mk_six(LIM_MIN, LIM_MIN, LIM_MIN, LIM_MIN, LIM_MIN, LIM_MIN));
      add_sample(mk_six(LIM_MAX, LIM_MIN, '0, 32'hffff_ffff, 32'h1, ONE_Q16), 1'b1,
                 mk_six(LIM_MAX, LIM_MIN, '0, 32'hffff_ffff, 32'h1, ONE_Q16));
      add_sample(mk_six(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                        32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa), 1'b1,
                 mk_six(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                        32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa));
      add_sample(mk_six(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                        32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555), 1'b1,
                 mk_six(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                        32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555));
      // extreme lever arm: torque overflows and must clamp
      add_write(CSR_OFFSET_X, LIM_MAX);
      add_write(CSR_OFFSET_Y, LIM_MIN);
      add_write(CSR_OFFSET_Z, LIM_MAX);
      add_sample(mk_six(LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX), 1'b0, '0);
      add_sample(mk_six(LIM_MIN, LIM_MIN, LIM_MIN, LIM_MIN, LIM_MIN, LIM_MIN), 1'b0, '0);
      add_sample(mk_six(ONE_Q16, -ONE_Q16, ONE_Q16 >> 1, '0, '0, '0), 1'b0, '0);
      // half turn about x: negating the most negative force saturates
      add_write(CSR_QUAT_X, Q30_POS);
      add_write(CSR_QUAT_W, '0);
      add_sample(mk_six(LIM_MIN, LIM_MIN, LIM_MIN, LIM_MIN, LIM_MIN, LIM_MIN), 1'b0, '0);
      add_sample(mk_six(ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16, LIM_MAX, '0, LIM_MIN), 1'b0, '0);
      // quaternion far from unit length, all components at the top of the range
      add_write(CSR_QUAT_Y, Q30_POS);
      add_write(CSR_QUAT_Z, Q30_POS);
      add_write(CSR_QUAT_W, Q30_POS);
      add_sample(mk_six(LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX), 1'b0, '0);
      add_sample(mk_six(LIM_MIN, LIM_MAX, ONE_Q16, -ONE_Q16, '0, LIM_MAX), 1'b0, '0);
      // and all at the bottom, with the lever arm flipped
      add_write(CSR_QUAT_X, Q30_NEG);
      add_write(CSR_QUAT_Y, Q30_NEG);
      add_write(CSR_QUAT_Z, Q30_NEG);
      add_write(CSR_QUAT_W, Q30_NEG);
      add_write(CSR_OFFSET_X, LIM_MIN);
      add_write(CSR_OFFSET_Y, LIM_MAX);
      add_write(CSR_OFFSET_Z, LIM_MIN);
      add_sample(mk_six(LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX), 1'b0, '0);
      add_sample(mk_six(LIM_MIN, LIM_MIN, LIM_MIN, LIM_MIN, LIM_MIN, LIM_MIN), 1'b0, '0);
      // a write past the last register must leave the frame untouched
      add_write(CSR_UNMAPPED, 32'hffff_ffff);
      add_sample(mk_six(ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16), 1'b0, '0);
      // quarter turn about z with a one metre arm along z
      add_write(CSR_QUAT_X, '0);
      add_write(CSR_QUAT_Y, '0);
      add_write(CSR_QUAT_Z, HALF_SQRT2);
      add_write(CSR_QUAT_W, HALF_SQRT2);
      add_write(CSR_OFFSET_X, '0);
      add_write(CSR_OFFSET_Y, '0);
      add_write(CSR_OFFSET_Z, ONE_Q16);
      add_sample(mk_six(ONE_Q16, '0, '0, '0, '0, '0), 1'b0, '0);
      add_sample(mk_six('0, ONE_Q16, '0, '0, ONE_Q16, '0), 1'b0, '0);
      add_sample(mk_six(32'h1234_5678, 32'hfedc_ba98, 32'h0f0f_0f0f,
                        32'hf0f0_f0f0, 32'h7654_3210, 32'h89ab_cdef), 1'b0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table with idling on both sides
      idle_on = 1'b1;
      foreach (stim_rows[n]) begin
         if (stim_rows[n].is_write)
            write_register(stim_rows[n].reg_index, stim_rows[n].reg_data);
         else
            send_sample(stim_rows[n].sample, stim_rows[n].typed, stim_rows[n].typed_result);
      end

      // random frames and requests; the last phase runs without any idling
      run_phase(FRAME_UNIT_NEAR, 1'b1, 150, 1'b1);
      run_phase(FRAME_UNIT_FAR,  1'b1, 150, 1'b0);
      run_phase(FRAME_LOOSE,     1'b1, 150, 1'b0);
      run_phase(FRAME_UNIT_NEAR, 1'b0, 150, 1'b0);
      run_phase(FRAME_EXTREME,   1'b1, 150, 1'b1);
      run_phase(FRAME_UNIT_FAR,  1'b1, 150, 1'b0);
      run_phase(FRAME_UNIT_NEAR, 1'b0, 150, 1'b0);

      // drain, then allow the pipeline depth twice over for stray responses
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_wrenches.size() != 0);
      repeat (2 * PIPE_DEPTH) @(posedge clock);

      if (mismatches == 0 && pending_wrenches.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
